// File: sv/flpa_pkg.sv
// Shared constants, types and helper functions of the free-list pool allocator.
package flpa_pkg;

    localparam int unsigned POOL_DEPTH = 64;
    localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
    localparam int unsigned LINK_W     = IDX_W + 1;
    localparam int unsigned ACT_W      = 7;
    localparam int unsigned ADDR_W     = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ACT_W-1:0]  act_t;

    localparam link_t NIL_LINK     = link_t'(POOL_DEPTH);
    localparam act_t  ACTIVE_RESET = act_t'(64);

    typedef enum logic [1:0]
    {
        STATUS_DONE     = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_NOT_USED = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_ACTIVE_ENTRIES = 1'b0;

    typedef struct packed
    {
        logic  mark;
        link_t link;
    } prev_word_t;

    function automatic link_t eff_count(input act_t act);
        int unsigned v;
        v = int'(act);
        if (v < 1)
        begin
            v = 1;
        end
        if (v > POOL_DEPTH)
        begin
            v = POOL_DEPTH;
        end
        return link_t'(v);
    endfunction

    function automatic link_t init_next(input idx_t i, input link_t n_eff);
        link_t succ;
        succ = link_t'(i) + link_t'(1);
        return (succ < n_eff) ? succ : NIL_LINK;
    endfunction

    function automatic logic [5:0] show_link(input link_t l);
        return (l != NIL_LINK) ? 6'(l) : 6'd0;
    endfunction

endpackage

// File: sv/free_list_pool_allocator.sv
// Fixed pool allocator with a LIFO free list and a doubly linked used list.
// The result of an allocate or a rejected free is loaded in the alloc or unlink state that follows
// the accepted beat, that of a free in the push state after the unlink state; the next beat is
// taken the cycle after the result is loaded. A stalled result holds back the next.
// Each link memory has one write port, and a free rewrites up to two words of each.
// Reset or a write of active_entries rebuilds both lists by clearing the per-entry valid bits.
module free_list_pool_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [flpa_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // entry_index[5:0], zero pad
    input  logic [0:0]                  s_tuser,  // op[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata   // status, granted_index, used_count,
                                                  // used_first, used_last, zero pad
);
    import flpa_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ALLOC,
        ST_UNLINK,
        ST_PUSH
    } state_t;

    link_t      next_link_mem [POOL_DEPTH];
    prev_word_t prev_link_mem [POOL_DEPTH];

    logic [POOL_DEPTH-1:0] next_vld_reg;
    logic [POOL_DEPTH-1:0] prev_vld_reg;
    link_t      nrd_reg;
    prev_word_t prd_reg;
    logic       nrd_vld_reg;
    logic       prd_vld_reg;

    state_t     state_reg, state_next;
    act_t       active_reg, active_next;
    link_t      free_head_reg, free_head_next;
    link_t      used_head_reg, used_head_next;
    link_t      used_tail_reg, used_tail_next;
    link_t      total_reg, total_next;
    idx_t       work_idx_reg, work_idx_next;
    logic       op_reg, op_next;
    logic       in_range_reg, in_range_next;
    logic       empty_reg, empty_next;
    logic       m_valid_reg, m_valid_next;
    status_t    status_reg, status_next;
    logic [5:0] granted_reg, granted_next;
    logic [6:0] count_reg, count_next;
    logic [5:0] first_reg, first_next;
    logic [5:0] last_reg, last_next;

    logic       accept;
    logic       cfg_wr;
    logic       out_free;
    logic       res_load;
    status_t    res_status;
    logic [5:0] res_granted;
    link_t      eff_n;
    link_t      rd_next;
    prev_word_t rd_prev;
    logic [5:0] s_entry;

    logic       nwe;
    idx_t       nwa;
    link_t      nwd;
    logic       pwe;
    idx_t       pwa;
    prev_word_t pwd;
    logic       re;
    idx_t       ra;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_ACTIVE_ENTRIES) ? 32'(active_reg) : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_ENTRIES);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign s_entry  = s_tdata[5:0];
    assign out_free = !m_valid_reg || m_tready;
    assign eff_n    = eff_count(active_reg);
    assign rd_next  = nrd_vld_reg ? nrd_reg : init_next(work_idx_reg, eff_n);
    assign rd_prev  = prd_vld_reg ? prd_reg : '{mark: 1'b0, link: NIL_LINK};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, last_reg, first_reg, count_reg, granted_reg, status_reg};

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        free_head_next = free_head_reg;
        used_head_next = used_head_reg;
        used_tail_next = used_tail_reg;
        total_next     = total_reg;
        work_idx_next  = work_idx_reg;
        op_next        = op_reg;
        in_range_next  = in_range_reg;
        empty_next     = empty_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        res_load       = 1'b0;
        res_status     = STATUS_DONE;
        res_granted    = 6'd0;
        nwe            = 1'b0;
        nwa            = work_idx_reg;
        nwd            = NIL_LINK;
        pwe            = 1'b0;
        pwa            = work_idx_reg;
        pwd            = '{mark: 1'b0, link: NIL_LINK};
        re             = 1'b0;
        ra             = idx_t'(s_entry);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = s_tuser[0];
                    in_range_next = (int'(s_entry) < POOL_DEPTH);
                    empty_next    = (free_head_reg == NIL_LINK);
                    re            = 1'b1;
                    if (s_tuser[0] == OP_ALLOC)
                    begin
                        ra         = idx_t'(free_head_reg);
                        state_next = ST_ALLOC;
                        if (free_head_reg != NIL_LINK)
                        begin
                            nwe = 1'b1;
                            nwa = ra;
                            nwd = NIL_LINK;
                            pwe = 1'b1;
                            pwa = ra;
                            pwd = '{mark: 1'b1, link: used_tail_reg};
                        end
                    end
                    else
                    begin
                        state_next = ST_UNLINK;
                    end
                    work_idx_next = ra;
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (empty_reg)
                    begin
                        res_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        if (used_tail_reg != NIL_LINK)
                        begin
                            nwe = 1'b1;
                            nwa = idx_t'(used_tail_reg);
                            nwd = link_t'(work_idx_reg);
                        end
                        else
                        begin
                            used_head_next = link_t'(work_idx_reg);
                        end
                        used_tail_next = link_t'(work_idx_reg);
                        free_head_next = rd_next;
                        total_next     = total_reg + link_t'(1);
                        res_granted    = 6'(work_idx_reg);
                    end
                end
            end
            ST_UNLINK:
            begin
                if (!in_range_reg || !rd_prev.mark)
                begin
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        res_status = STATUS_NOT_USED;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (rd_prev.link != NIL_LINK)
                    begin
                        nwe = 1'b1;
                        nwa = idx_t'(rd_prev.link);
                        nwd = rd_next;
                    end
                    else
                    begin
                        used_head_next = rd_next;
                    end
                    if (rd_next != NIL_LINK)
                    begin
                        pwe = 1'b1;
                        pwa = idx_t'(rd_next);
                        pwd = '{mark: 1'b1, link: rd_prev.link};
                    end
                    else
                    begin
                        used_tail_next = rd_prev.link;
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    nwe            = 1'b1;
                    nwa            = work_idx_reg;
                    nwd            = free_head_reg;
                    pwe            = 1'b1;
                    pwa            = work_idx_reg;
                    pwd            = '{mark: 1'b0, link: NIL_LINK};
                    free_head_next = link_t'(work_idx_reg);
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - link_t'(1);
                    end
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load)
        begin
            m_valid_next = 1'b1;
            status_next  = res_status;
            granted_next = res_granted;
            count_next   = 7'(total_next);
            first_next   = show_link(used_head_next);
            last_next    = show_link(used_tail_next);
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            active_next    = pwdata[ACT_W-1:0];
            free_head_next = '0;
            used_head_next = NIL_LINK;
            used_tail_next = NIL_LINK;
            total_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_RESET;
            free_head_reg <= '0;
            used_head_reg <= NIL_LINK;
            used_tail_reg <= NIL_LINK;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            work_idx_reg  <= '0;
            op_reg        <= OP_ALLOC;
            in_range_reg  <= 1'b0;
            empty_reg     <= 1'b0;
            status_reg    <= STATUS_DONE;
            granted_reg   <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            used_tail_reg <= used_tail_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            work_idx_reg  <= work_idx_next;
            op_reg        <= op_next;
            in_range_reg  <= in_range_next;
            empty_reg     <= empty_next;
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
            nrd_vld_reg  <= 1'b0;
            prd_vld_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
        end
        else
        begin
            if (nwe)
            begin
                next_vld_reg[nwa] <= 1'b1;
            end
            if (pwe)
            begin
                prev_vld_reg[pwa] <= 1'b1;
            end
            if (re)
            begin
                nrd_vld_reg <= next_vld_reg[ra];
                prd_vld_reg <= prev_vld_reg[ra];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            next_link_mem[nwa] <= nwd;
        end
        if (re)
        begin
            nrd_reg <= next_link_mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            prev_link_mem[pwa] <= pwd;
        end
        if (re)
        begin
            prd_reg <= prev_link_mem[ra];
        end
    end

    // The used count never exceeds the pool depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= link_t'(POOL_DEPTH))
        else $error("used count exceeds the pool depth");

    // Between operations, the used list is empty exactly when the count is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ((used_head_reg == NIL_LINK) == (total_reg == '0)))
        else $error("used list head disagrees with the used count");

    // Between operations, the used list head and tail are null together.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ((used_head_reg == NIL_LINK) == (used_tail_reg == NIL_LINK)))
        else $error("used list head and tail disagree");

    // An empty report on allocate means every active entry is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && status_reg == STATUS_EMPTY |-> total_reg == eff_n)
        else $error("pool reported empty while entries are free");

    // A free operation always goes through the unlink step.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> $past(state_reg) == ST_UNLINK || $past(state_reg) == ST_PUSH)
        else $error("push step entered without an unlink step");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the free-list pool allocator.
module testbench;
    import flpa_pkg::*;

    localparam logic [ADDR_W-1:0] ACTIVE_ADDR   = ADDR_W'(4 * REG_ACTIVE_ENTRIES);
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

    typedef struct
    {
        status_t status;
        idx_t    granted;
        act_t    count;
        idx_t    first;
        idx_t    last;
    } alloc_result_t;

    class alloc_scoreboard;
        link_t         nxt[POOL_DEPTH];
        link_t         prv[POOL_DEPTH];
        bit            in_use[POOL_DEPTH];
        link_t         free_top;
        link_t         used_top;
        link_t         used_end;
        int unsigned   total;
        act_t          active_reg;
        alloc_result_t owed[$];
        int            errors;

        function new();
            errors     = 0;
            active_reg = act_t'(64);
            rebuild();
        endfunction

        function void rebuild();
            int unsigned n;
            n = active_reg;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > POOL_DEPTH)
            begin
                n = POOL_DEPTH;
            end
            for (int unsigned i = 0; i < POOL_DEPTH; i++)
            begin
                nxt[i]    = (i + 1 < n) ? link_t'(i + 1) : NIL_LINK;
                prv[i]    = NIL_LINK;
                in_use[i] = 1'b0;
            end
            free_top = '0;
            used_top = NIL_LINK;
            used_end = NIL_LINK;
            total    = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ACTIVE_ADDR)
            begin
                active_reg = data[ACT_W-1:0];
                rebuild();
            end
        endfunction

        function idx_t visible(link_t l);
            return (l != NIL_LINK) ? idx_t'(l) : idx_t'(0);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function idx_t pick_in_use();
            idx_t pool[$];
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                if (in_use[i])
                begin
                    pool.push_back(idx_t'(i));
                end
            end
            if (pool.size() == 0)
            begin
                return idx_t'($urandom_range(0, POOL_DEPTH - 1));
            end
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function void note_request(logic op, idx_t idx);
            alloc_result_t r;
            link_t         e;
            link_t         p;
            link_t         s;
            r.status  = STATUS_DONE;
            r.granted = '0;
            if (op == OP_ALLOC)
            begin
                e = free_top;
                if (e == NIL_LINK)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    free_top          = nxt[idx_t'(e)];
                    nxt[idx_t'(e)]    = NIL_LINK;
                    prv[idx_t'(e)]    = used_end;
                    if (used_end != NIL_LINK)
                    begin
                        nxt[idx_t'(used_end)] = e;
                    end
                    else
                    begin
                        used_top = e;
                    end
                    used_end          = e;
                    in_use[idx_t'(e)] = 1'b1;
                    total++;
                    r.granted = idx_t'(e);
                end
            end
            else
            begin
                if (!in_use[idx])
                begin
                    r.status = STATUS_NOT_USED;
                end
                else
                begin
                    p = prv[idx];
                    s = nxt[idx];
                    if (p != NIL_LINK)
                    begin
                        nxt[idx_t'(p)] = s;
                    end
                    else
                    begin
                        used_top = s;
                    end
                    if (s != NIL_LINK)
                    begin
                        prv[idx_t'(s)] = p;
                    end
                    else
                    begin
                        used_end = p;
                    end
                    prv[idx]    = NIL_LINK;
                    nxt[idx]    = free_top;
                    free_top    = link_t'(idx);
                    in_use[idx] = 1'b0;
                    if (total > 0)
                    begin
                        total--;
                    end
                end
            end
            r.count = act_t'(total);
            r.first = visible(used_top);
            r.last  = visible(used_end);
            owed.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] beat);
            alloc_result_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("unexpected result beat, tdata", int'(beat), 0);
                return;
            end
            want = owed.pop_front();
            if (beat[1:0] != want.status)
            begin
                report_mismatch("status", beat[1:0], want.status);
            end
            if (beat[7:2] != want.granted)
            begin
                report_mismatch("granted_index", beat[7:2], want.granted);
            end
            if (beat[14:8] != want.count)
            begin
                report_mismatch("used_count", beat[14:8], want.count);
            end
            if (beat[20:15] != want.first)
            begin
                report_mismatch("used_first", beat[20:15], want.first);
            end
            if (beat[26:21] != want.last)
            begin
                report_mismatch("used_last", beat[26:21], want.last);
            end
            if (beat[31:27] != '0)
            begin
                report_mismatch("padding", beat[31:27], 0);
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;

    alloc_scoreboard   book;
    int                burst_left;
    int unsigned       stall_cycle;

    free_list_pool_allocator u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        m_tready    = 1'b0;
        stall_cycle = 0;
        forever
        begin
            @(negedge clk);
            stall_cycle++;
            case ((stall_cycle / 60) % 4)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = ((stall_cycle % 7) < 2);
                default: m_tready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                book.check_result(m_tdata);
            end
        end
    end

    task automatic push_op(input logic op, input idx_t idx);
        int gap;
        s_tuser  = op;
        s_tdata  = {2'b00, idx};
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        book.note_request(op, idx);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (book.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        settle();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        book.write_reg(addr, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] active, input int count, input int alloc_pct);
        int r;
        write_register(ACTIVE_ADDR, active);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
            begin
                push_op(OP_ALLOC, idx_t'($urandom_range(0, POOL_DEPTH - 1)));
            end
            else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4)
            begin
                push_op(OP_FREE, book.pick_in_use());
            end
            else
            begin
                push_op(OP_FREE, idx_t'($urandom_range(0, POOL_DEPTH - 1)));
            end
        end
    endtask

    initial
    begin
        book       = new();
        burst_left = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        push_op(OP_FREE, idx_t'(5));
        repeat (4) push_op(OP_ALLOC, idx_t'(0));
        push_op(OP_FREE, idx_t'(1));
        push_op(OP_FREE, idx_t'(0));
        push_op(OP_FREE, idx_t'(3));
        push_op(OP_FREE, idx_t'(3));
        push_op(OP_ALLOC, idx_t'(63));
        push_op(OP_FREE, idx_t'(63));
        push_op(OP_FREE, idx_t'(2));
        push_op(OP_FREE, idx_t'(3));

        write_register(ACTIVE_ADDR, 32'd1);
        push_op(OP_ALLOC, idx_t'(0));
        push_op(OP_ALLOC, idx_t'(0));
        push_op(OP_FREE, idx_t'(63));
        push_op(OP_FREE, idx_t'(0));

        write_register(ACTIVE_ADDR, 32'd0);
        push_op(OP_ALLOC, idx_t'(0));
        push_op(OP_ALLOC, idx_t'(0));
        write_register(UNMAPPED_ADDR, 32'd5);
        push_op(OP_ALLOC, idx_t'(0));

        write_register(ACTIVE_ADDR, 32'd2);
        repeat (3) push_op(OP_ALLOC, idx_t'(0));
        push_op(OP_FREE, idx_t'(1));
        push_op(OP_FREE, idx_t'(0));

        run_phase(32'd127, 110, 90);
        run_phase(32'd3, 40, 50);
        run_phase(32'd1, 30, 50);
        run_phase(32'($urandom_range(4, 63)), 50, 60);
        run_phase(32'd64, 50, 55);
        run_phase(32'd2, 30, 50);
        run_phase(32'($urandom_range(0, 127)), 50, 65);
        run_phase(32'd5, 40, 45);

        settle();
        repeat (10) @(posedge clk);
        if (book.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
